### sv/line_crossing_tracker_core_assert.svh
// assertion macros shared by the line crossing tracker checkers
`ifndef LINE_CROSSING_TRACKER_CORE_ASSERT_SVH
`define LINE_CROSSING_TRACKER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LCT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lct assertion failed");

// next-cycle implication, disabled in reset
`define LCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lct assertion failed");

`endif

### sv/lct_pkg.sv
// types, codes and constants of the line crossing tracker
package lct_pkg;

  localparam logic [9:0] FULL_TURN      = 10'd360;
  localparam logic [9:0] HALF_TURN      = 10'd180;
  localparam logic [8:0] BRAKE_CONE_DEG = 9'd60;

  typedef logic signed [9:0] size_t;

  localparam size_t SIZE_NONE = -10'sd100;
  localparam size_t SIZE_LOST = 10'sd300;
  localparam size_t SIZE_FULL = 10'sd200;
  localparam size_t SIZE_ONE  = 10'sd100;

  localparam logic [7:0] CROSSOVER_RESET  = 8'd90;
  localparam logic [8:0] BIG_LIMIT_RESET   = 9'd150;
  localparam logic [8:0] SMALL_LIMIT_RESET = 9'd50;
  localparam logic [7:0] ESCAPE_RESET      = 8'd100;

  typedef enum logic [1:0] {
    CFG_CROSSOVER_BUFFER = 2'd0,
    CFG_BIG_SIZE_LIMIT   = 2'd1,
    CFG_SMALL_SIZE_LIMIT = 2'd2,
    CFG_ESCAPE_SPEED     = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic       line_seen;
    logic [8:0] line_angle;
    logic [7:0] line_size;
    logic [8:0] heading;
    logic       ball_seen;
    logic [8:0] move_direction;
    logic [7:0] move_speed;
  } in_item_t;

  typedef struct packed {
    logic [8:0] drive_direction;
    logic [7:0] drive_speed;
    logic       brake;
    logic       on_field;
  } out_item_t;

  typedef struct packed {
    logic [7:0] crossover_buffer_deg;
    logic [8:0] big_size_limit;
    logic [8:0] small_size_limit;
    logic [7:0] escape_speed;
  } lct_cfg_t;

  typedef struct packed {
    logic       inside_field;
    logic [8:0] tracked_line_angle;
    size_t      tracked_line_size;
  } lct_state_t;

endpackage

### sv/lct_step.sv
// one-sample line tracking update and drive override logic
module lct_step import lct_pkg::*; (
  input  in_item_t   item,
  input  lct_state_t state,
  input  lct_cfg_t   cfg,
  output lct_state_t state_nxt,
  output out_item_t  result
);

  function automatic logic [8:0] wrap360(input logic [9:0] v);
    return (v >= FULL_TURN) ? 9'(v - FULL_TURN) : v[8:0];
  endfunction

  function automatic logic [8:0] gap_deg(input logic [8:0] a, input logic [8:0] b);
    logic [8:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return ({1'b0, d} > HALF_TURN) ? 9'(FULL_TURN - {1'b0, d}) : d;
  endfunction

  logic [8:0]        head;
  logic [8:0]        dir;
  logic [8:0]        ang;
  logic [8:0]        mirror_ang;
  size_t             line_sz;
  size_t             mirror_sz;
  logic [8:0]        esc_base;
  logic [8:0]        esc_dir;
  logic signed [10:0] size_w;
  logic signed [10:0] big_w;
  logic signed [10:0] small_w;

  always_comb begin
    head       = wrap360({1'b0, item.heading});
    dir        = wrap360({1'b0, item.move_direction});
    ang        = wrap360({1'b0, wrap360({1'b0, item.line_angle})} + {1'b0, head});
    mirror_ang = wrap360({1'b0, ang} + HALF_TURN);
    line_sz    = size_t'({2'b00, item.line_size});
    mirror_sz  = SIZE_FULL - line_sz;

    state_nxt = state;
    if (state.inside_field) begin
      if (item.line_seen) begin
        state_nxt.inside_field       = 1'b0;
        state_nxt.tracked_line_angle = ang;
        state_nxt.tracked_line_size  = line_sz;
      end
    end else if (state.tracked_line_size == SIZE_LOST) begin
      if (item.line_seen) begin
        state_nxt.tracked_line_angle = mirror_ang;
        state_nxt.tracked_line_size  = mirror_sz;
      end
    end else if (!item.line_seen) begin
      if (state.tracked_line_size <= SIZE_ONE) begin
        state_nxt.inside_field       = 1'b1;
        state_nxt.tracked_line_size  = SIZE_NONE;
        state_nxt.tracked_line_angle = '0;
      end else begin
        state_nxt.tracked_line_size = SIZE_LOST;
      end
    end else if (gap_deg(ang, state.tracked_line_angle) > {1'b0, cfg.crossover_buffer_deg}) begin
      state_nxt.tracked_line_angle = mirror_ang;
      state_nxt.tracked_line_size  = mirror_sz;
    end else begin
      state_nxt.tracked_line_angle = ang;
      state_nxt.tracked_line_size  = line_sz;
    end
  end

  always_comb begin
    size_w   = {state_nxt.tracked_line_size[9], state_nxt.tracked_line_size};
    big_w    = signed'({2'b00, cfg.big_size_limit});
    small_w  = signed'({2'b00, cfg.small_size_limit});
    esc_base = wrap360({1'b0, state_nxt.tracked_line_angle} + HALF_TURN);
    esc_dir  = wrap360({1'b0, esc_base} + FULL_TURN - {1'b0, head});

    result.drive_direction = dir;
    result.drive_speed     = item.move_speed;
    result.brake           = 1'b0;
    result.on_field        = state_nxt.inside_field;
    if (!state_nxt.inside_field) begin
      if (size_w > big_w) begin
        result.drive_direction = esc_dir;
        result.drive_speed     = cfg.escape_speed;
      end else if (size_w >= small_w && item.ball_seen && item.line_seen) begin
        if (gap_deg(ang, dir) <= BRAKE_CONE_DEG) begin
          result.drive_speed = '0;
          result.brake       = 1'b1;
        end
      end
    end
  end

endmodule

### sv/line_crossing_tracker_core.sv
// top level of the line crossing tracker
// One sensor sample per clock is taken while no result is held by out_stall. An accepted
// transaction sits in the input register while lct_step updates the field/line state and
// computes the drive override from it; the result register loads when the sample advances,
// which waits while a result is held by out_stall. in_stall rises only while a result is
// held by out_stall and the input register is full; configuration writes are always ready.
module line_crossing_tracker_core import lct_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  logic       in_valid_r;
  in_item_t   in_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  lct_state_t state_r;
  lct_state_t state_nxt;
  lct_cfg_t   cfg_r;
  out_item_t  result;
  logic       advance;

  lct_step u_step (
    .item      (in_item_r),
    .state     (state_r),
    .cfg       (cfg_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.inside_field       <= 1'b1;
      state_r.tracked_line_angle <= '0;
      state_r.tracked_line_size  <= SIZE_NONE;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crossover_buffer_deg <= CROSSOVER_RESET;
      cfg_r.big_size_limit       <= BIG_LIMIT_RESET;
      cfg_r.small_size_limit     <= SMALL_LIMIT_RESET;
      cfg_r.escape_speed         <= ESCAPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_CROSSOVER_BUFFER: cfg_r.crossover_buffer_deg <= cfg_data[7:0];
        CFG_BIG_SIZE_LIMIT:   cfg_r.big_size_limit       <= cfg_data;
        CFG_SMALL_SIZE_LIMIT: cfg_r.small_size_limit     <= cfg_data;
        CFG_ESCAPE_SPEED:     cfg_r.escape_speed         <= cfg_data[7:0];
      endcase
    end
  end

endmodule

### sv/lct_checker.sv
// port-level assertions of the line crossing tracker and their bind
`include "line_crossing_tracker_core_assert.svh"

module lct_checker import lct_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  `LCT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))
  `LCT_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall)
  `LCT_ASSERT_IMPL(a_rise_after_accept, $rose(out_valid), $past(in_valid && !in_stall, 2))
  `LCT_ASSERT_IMPL(a_brake_off_field, out_valid && out_item.brake,
                   out_item.drive_speed == 8'd0 && !out_item.on_field)

endmodule

bind line_crossing_tracker_core lct_checker u_lct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

### sim/line_crossing_tracker_core_tb.sv
// self-checking testbench for line_crossing_tracker_core: directed table, random line crossings
`timescale 1ns / 1ps

module line_crossing_tracker_core_tb;
  import lct_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DIRECTED_ROWS  = 21;
  localparam int PHASES         = 6;
  localparam int RANDOM_ITEMS   = 1300;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_CROSSOVER_BUFFER;
  logic [8:0] cfg_data  = '0;

  // tracker state and register copies
  logic       trk_inside = 1'b1;
  logic [8:0] trk_angle  = '0;
  size_t      trk_size   = SIZE_NONE;
  int         lim_crossover = int'(CROSSOVER_RESET);
  int         lim_big       = int'(BIG_LIMIT_RESET);
  int         lim_small     = int'(SMALL_LIMIT_RESET);
  int         esc_speed     = int'(ESCAPE_RESET);

  out_item_t  drive_q [$];
  out_item_t  want;
  int         mismatches   = 0;
  int         quiet_cycles = 0;
  int         tx_idle_pct  = 6;
  int         rx_idle_pct  = 65;

  // seen, angle, size, heading, ball, direction, speed, typed, direction, speed, brake, on_field
  int directed_tab [DIRECTED_ROWS][12] = '{
    '{0,   0,   0,   0, 1,  10,  20, 1,  10,  20, 0, 1},
    '{0,   0,   0, 359, 1, 359, 255, 1, 359, 255, 0, 1},
    '{0,   0,   0,   0, 0, 511,   0, 1, 151,   0, 0, 1},
    '{1,  90,  40,   0, 1,  90,  50, 1,  90,  50, 0, 0},
    '{1, 100,  60,   0, 1, 100,  70, 1, 100,   0, 1, 0},
    '{1, 100,  60,   0, 0, 100,  70, 0,   0,   0, 0, 0},
    '{1, 100,  60,   0, 1, 161,  70, 0,   0,   0, 0, 0},
    '{1, 100,  60,   0, 1, 160,  70, 0,   0,   0, 0, 0},
    '{1, 110, 160,   0, 1,   0,  30, 1, 290, 100, 0, 0},
    '{0,   0,   0,  20, 1,   5,  30, 1, 270, 100, 0, 0},
    '{0,   0,   0,   0, 1,   5,  30, 0,   0,   0, 0, 0},
    '{1, 300, 200,   0, 1, 120,  40, 0,   0,   0, 0, 0},
    '{1, 120, 255,   0, 1, 120,  40, 0,   0,   0, 0, 0},
    '{1, 300, 255,   0, 1, 120,  40, 0,   0,   0, 0, 0},
    '{0,   0,   0,   0, 1, 200,  40, 0,   0,   0, 0, 0},
    '{1, 511,   0, 511, 0,   0,   0, 0,   0,   0, 0, 0},
    '{1, 359, 200, 359, 1,   0,   0, 0,   0,   0, 0, 0},
    '{0,   0,   0,   0, 1,   0,   0, 0,   0,   0, 0, 0},
    '{0,   0,   0,   0, 1,   0,   0, 0,   0,   0, 0, 0},
    '{1,   0, 200,   0, 1,   0,   0, 0,   0,   0, 0, 0},
    '{0,   0,   0,   0, 0,   0,   0, 0,   0,   0, 0, 0}
  };

  // crossover, big limit, small limit, escape speed; phase 4 is drawn at random
  int reg_sets [PHASES][4] = '{
    '{ 90, 150,  50, 100},
    '{  0,   0,   0,   0},
    '{180, 300, 300, 255},
    '{255, 511, 511,   7},
    '{  0,   0,   0,   0},
    '{ 45, 120,  20, 200}
  };

  line_crossing_tracker_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int angle_gap(input int a, input int b);
    int d;
    d = (a >= b) ? a - b : b - a;
    return (d > 180) ? 360 - d : d;
  endfunction

  function automatic void take_line(input int ang, input int size, input bit mirror);
    if (mirror) begin
      trk_angle = 9'((ang + int'(HALF_TURN)) % int'(FULL_TURN));
      trk_size  = SIZE_FULL - size_t'(size);
    end else begin
      trk_angle = 9'(ang);
      trk_size  = size_t'(size);
    end
  endfunction

  function automatic out_item_t predict_drive(input in_item_t it);
    int        ang, head, dir, spd, size;
    bit        brk;
    out_item_t r;
    head = int'(it.heading) % 360;
    dir  = int'(it.move_direction) % 360;
    spd  = int'(it.move_speed);
    size = int'(it.line_size);
    ang  = (int'(it.line_angle) % 360 + head) % 360;
    brk  = 1'b0;
    if (trk_inside) begin
      if (it.line_seen) begin
        trk_inside = 1'b0;
        take_line(ang, size, 1'b0);
      end
    end else if (trk_size == SIZE_LOST) begin
      if (it.line_seen) take_line(ang, size, 1'b1);
    end else if (!it.line_seen) begin
      if (trk_size <= SIZE_ONE) begin
        trk_inside = 1'b1;
        trk_size   = SIZE_NONE;
        trk_angle  = '0;
      end else begin
        trk_size = SIZE_LOST;
      end
    end else begin
      take_line(ang, size, angle_gap(ang, int'(trk_angle)) > lim_crossover);
    end
    if (!trk_inside) begin
      if (int'(trk_size) > lim_big) begin
        dir = (int'(trk_angle) + 180 + 360 - head) % 360;
        spd = esc_speed;
      end else if (int'(trk_size) >= lim_small && it.ball_seen && it.line_seen) begin
        if (angle_gap(ang, dir) <= int'(BRAKE_CONE_DEG)) begin
          spd = 0;
          brk = 1'b1;
        end
      end
    end
    r.drive_direction = 9'(dir);
    r.drive_speed     = 8'(spd);
    r.brake           = brk;
    r.on_field        = trk_inside;
    return r;
  endfunction

  // reduce to 0..359, sometimes shifted up by a full turn where it still fits
  function automatic logic [8:0] wrap_angle(input int deg);
    int d;
    d = ((deg % 360) + 360) % 360;
    if (d < 152 && $urandom_range(0, 19) == 0) d += 360;
    return 9'(d);
  endfunction

  function automatic void check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $error("%s expected %0d got %0d", name, exp_val, got_val);
      mismatches++;
    end
  endfunction

  task automatic send_item(input in_item_t it, input bit typed_valid, input out_item_t typed);
    out_item_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    predicted = predict_drive(it);
    drive_q.push_back(typed_valid ? typed : predicted);
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (drive_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 9'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CROSSOVER_BUFFER: lim_crossover = value & 'hFF;
      CFG_BIG_SIZE_LIMIT:   lim_big       = value & 'h1FF;
      CFG_SMALL_SIZE_LIMIT: lim_small     = value & 'h1FF;
      CFG_ESCAPE_SPEED:     esc_speed     = value & 'hFF;
      default: ;
    endcase
  endtask

  task automatic load_registers(input int crossover, input int big, input int small_lim,
                                input int escape);
    go_idle();
    wait_drained();
    write_reg(CFG_CROSSOVER_BUFFER, crossover);
    write_reg(CFG_BIG_SIZE_LIMIT, big);
    write_reg(CFG_SMALL_SIZE_LIMIT, small_lim);
    write_reg(CFG_ESCAPE_SPEED, escape);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly line crossing episodes around one angle, with flips and a trailing loss of line
  task automatic drive_random(input int n_items);
    int          sent, base, head, len, fld;
    bit          crossed;
    logic [63:0] noise;
    in_item_t    it;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        noise = {$urandom, $urandom};
        it = noise[$bits(in_item_t)-1:0];
        send_item(it, 1'b0, '0);
        sent++;
      end else begin
        base    = int'($urandom_range(0, 359));
        head    = int'($urandom_range(0, 359));
        len     = int'($urandom_range(3, 24));
        crossed = 1'b0;
        for (int k = 0; k < len + 3 && sent < n_items; k++) begin
          if ($urandom_range(0, 99) < 15) crossed = !crossed;
          fld  = base + (crossed ? 180 : 0) + int'($urandom_range(0, 60)) - 30;
          head = (head + int'($urandom_range(0, 10)) - 5 + 360) % 360;
          it.line_seen  = (k < len) && ($urandom_range(0, 99) < 85);
          it.line_angle = wrap_angle(fld - head);
          it.line_size  = ($urandom_range(0, 24) == 0) ? 8'($urandom_range(201, 255))
                                                       : 8'($urandom_range(0, 200));
          it.heading    = wrap_angle(head);
          it.ball_seen  = 1'($urandom_range(0, 1));
          it.move_direction = ($urandom_range(0, 9) < 6)
                              ? wrap_angle(fld + int'($urandom_range(0, 140)) - 70)
                              : wrap_angle(int'($urandom_range(0, 359)));
          it.move_speed = 8'($urandom_range(0, 255));
          send_item(it, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (drive_q.size() == 0) begin
        $error("result transaction with no expectation waiting");
        mismatches++;
      end else begin
        want = drive_q.pop_front();
        check_field("drive_direction", int'(want.drive_direction),
                    int'(out_item.drive_direction));
        check_field("drive_speed", int'(want.drive_speed), int'(out_item.drive_speed));
        check_field("brake", int'(want.brake), int'(out_item.brake));
        check_field("on_field", int'(want.on_field), int'(out_item.on_field));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    in_item_t  it;
    out_item_t typed;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      it.line_seen       = 1'(directed_tab[i][0]);
      it.line_angle      = 9'(directed_tab[i][1]);
      it.line_size       = 8'(directed_tab[i][2]);
      it.heading         = 9'(directed_tab[i][3]);
      it.ball_seen       = 1'(directed_tab[i][4]);
      it.move_direction  = 9'(directed_tab[i][5]);
      it.move_speed      = 8'(directed_tab[i][6]);
      typed.drive_direction = 9'(directed_tab[i][8]);
      typed.drive_speed     = 8'(directed_tab[i][9]);
      typed.brake           = 1'(directed_tab[i][10]);
      typed.on_field        = 1'(directed_tab[i][11]);
      send_item(it, directed_tab[i][7] != 0, typed);
    end

    for (int p = 0; p < PHASES; p++) begin
      tx_idle_pct = (p < 2) ? 6 : (p < 4) ? 65 : 0;
      rx_idle_pct = (p < 2) ? 65 : (p < 4) ? 6 : 0;
      if (p == 4) begin
        load_registers(int'($urandom_range(0, 180)), int'($urandom_range(0, 300)),
                       int'($urandom_range(0, 300)), int'($urandom_range(0, 255)));
      end else begin
        load_registers(reg_sets[p][0], reg_sets[p][1], reg_sets[p][2], reg_sets[p][3]);
      end
      drive_random(RANDOM_ITEMS / PHASES);
    end

    go_idle();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/lct_pkg.sv
sv/lct_step.sv
sv/line_crossing_tracker_core.sv
sv/lct_checker.sv
sim/line_crossing_tracker_core_tb.sv
